### design/utf8_to_utf16_transcoder_defines.svh
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define U8U16_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define U8U16_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8U16_ASSERT(label, prop, msg)
`define U8U16_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### design/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] unit_t;

	// Most units one input byte can cause.
	localparam int MaxUnits = 4;
	localparam int MaxPend  = 3;

	localparam unit_t REPL_UNIT = 16'hFFFD;
	localparam unit_t HI_SURR   = 16'hD800;
	localparam unit_t LO_SURR   = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// Encoded value equals the number of continuation bytes a lead needs.
	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_LEAD2 = 3'd1,
		CLS_LEAD3 = 3'd2,
		CLS_LEAD4 = 3'd3,
		CLS_BAD   = 3'd4
	} cls_t;

	// Units caused by one input byte, handed from the decoder to the output stage.
	typedef struct packed {
		logic [MaxUnits-1:0][15:0] units;
		logic [2:0]                count;
		logic                      text_end;
	} group_t;

endpackage

### design/u8u16_dec.sv
// Byte decoder: pending lead buffer plus single-pass decode of one byte.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_dec
	import u8u16_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  byte_t  in_byte,
	input  logic   end_of_text,
	output group_t grp
);

	byte_t      pend_q [MaxPend];
	logic [1:0] pend_cnt_q;

	byte_t      pend_nxt [MaxPend];
	logic [1:0] pend_cnt_nxt;

	function automatic cls_t byte_class(byte_t b);
		cls_t c;
		if (b inside {[8'h00:8'h7F]}) c = CLS_ASCII;
		else if (b inside {[8'hC0:8'hDF]}) c = CLS_LEAD2;
		else if (b inside {[8'hE0:8'hEF]}) c = CLS_LEAD3;
		else if (b inside {[8'hF0:8'hF7]}) c = CLS_LEAD4;
		else c = CLS_BAD;
		return c;
	endfunction

	always_comb begin
		byte_t       win [MaxUnits];
		logic [2:0]  n;
		logic [2:0]  pos;
		logic [2:0]  avail;
		logic [2:0]  need;
		logic [2:0]  cnt;
		logic        stop;
		byte_t       b;
		byte_t       c1;
		byte_t       c2;
		byte_t       c3;
		cls_t        cls;
		logic [20:0] v;
		logic [20:0] w;
		unit_t       u0;
		unit_t       u1;
		logic [1:0]  nu;
		for (int i = 0; i < MaxPend; i++) win[i] = pend_q[i];
		win[MaxUnits-1] = pend_q[MaxPend-1];
		win[pend_cnt_q] = in_byte;
		n    = {1'b0, pend_cnt_q} + 3'd1;
		pos  = 3'd0;
		cnt  = 3'd0;
		stop = 1'b0;
		grp.units = '0;
		for (int k = 0; k < MaxUnits; k++) begin
			b     = win[pos[1:0]];
			c1    = win[pos[1:0] + 2'd1];
			c2    = win[pos[1:0] + 2'd2];
			c3    = win[pos[1:0] + 2'd3];
			cls   = byte_class(b);
			avail = n - pos;
			need  = cls + 3'd1;
			u0    = REPL_UNIT;
			u1    = REPL_UNIT;
			nu    = 2'd0;
			v     = '0;
			w     = '0;
			if (!stop && pos < n) begin
				if (cls == CLS_ASCII) begin
					u0  = {8'h00, b};
					nu  = 2'd1;
					pos = pos + 3'd1;
				end else if (cls == CLS_BAD) begin
					nu  = 2'd1;
					pos = pos + 3'd1;
				end else if (avail >= need) begin
					case (cls)
						CLS_LEAD2: v = {10'd0, b[4:0], c1[5:0]};
						CLS_LEAD3: v = {5'd0, b[3:0], c1[5:0], c2[5:0]};
						CLS_LEAD4: v = {b[2:0], c1[5:0], c2[5:0], c3[5:0]};
						default:   v = '0;
					endcase
					if (v >= SUPP_BASE) begin
						w  = v - SUPP_BASE;
						u0 = HI_SURR + {5'd0, w[20:10]};
						u1 = LO_SURR + {6'd0, w[9:0]};
						nu = 2'd2;
					end else begin
						u0 = v[15:0];
						nu = 2'd1;
					end
					pos = pos + need;
				end else if (end_of_text) begin
					// text ends inside a sequence: replace the lead, rescan the rest
					nu  = 2'd1;
					pos = pos + 3'd1;
				end else begin
					stop = 1'b1;
				end
			end
			if (nu != 2'd0 && cnt < 3'(MaxUnits)) begin
				grp.units[cnt[1:0]] = u0;
				cnt = cnt + 3'd1;
			end
			if (nu == 2'd2 && cnt < 3'(MaxUnits)) begin
				grp.units[cnt[1:0]] = u1;
				cnt = cnt + 3'd1;
			end
		end
		for (int i = 0; i < MaxPend; i++) pend_nxt[i] = win[pos[1:0] + 2'(i)];
		pend_cnt_nxt = 2'(n - pos);
		grp.count    = cnt;
		grp.text_end = end_of_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (advance) begin
			pend_cnt_q <= pend_cnt_nxt;
		end
	end

	// buffered bytes are only read below the count
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MaxPend; i++) pend_q[i] <= pend_nxt[i];
		end
	end

endmodule

### design/u8u16_ser.sv
// Result register: holds the units of one byte and sends them one per cycle while m_tready is high.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_ser
	import u8u16_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  group_t grp,
	output logic   can_load,
	output logic   m_tvalid,
	input  logic   m_tready,
	output unit_t  m_tdata,
	output logic   m_tlast,
	output logic   m_tuser
);

	logic [MaxUnits-1:0][15:0] units_s2;
	logic [2:0]                rem_s2;
	logic                      end_s2;

	logic send;

	assign m_tvalid = (rem_s2 != 3'd0);
	assign send     = m_tvalid && m_tready;
	assign can_load = (rem_s2 == 3'd0) || (rem_s2 == 3'd1 && m_tready);
	assign m_tdata  = units_s2[0];
	assign m_tlast  = (rem_s2 == 3'd1);
	assign m_tuser  = end_s2 && (rem_s2 == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= '0;
		end else if (load) begin
			rem_s2 <= grp.count;
		end else if (send) begin
			rem_s2 <= rem_s2 - 3'd1;
		end
	end

	// advance the queue by one unit per request sent
	always_ff @(posedge clk) begin
		if (load) begin
			units_s2 <= grp.units;
			end_s2   <= grp.text_end;
		end else if (send) begin
			for (int i = 0; i < MaxUnits - 1; i++) units_s2[i] <= units_s2[i+1];
			units_s2[MaxUnits-1] <= REPL_UNIT;
		end
	end

endmodule

### design/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_dec, u8u16_ser and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_defines.svh"

// One text byte enters per request and UTF-16 code units leave one per request.
// A byte goes through an input register, then is decoded together with the
// buffered lead bytes in a single combinational pass into a result register,
// from which the units of the byte are offered. A byte giving several units
// (a surrogate pair or an end-of-text flush) drains from the result register
// one unit per cycle while m_tready is high, and holds the input until its
// final unit is sent (at most four units per byte).
// tlast marks the final unit caused by a byte, tuser the final unit of the text.

module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tlast,   // last_of_run
	output logic        m_tuser    // [0] text_done
);

	logic   v_s1;
	byte_t  byte_s1;
	logic   end_s1;
	logic   can_load;
	logic   advance;
	group_t grp;

	assign advance  = v_s1 && can_load;
	assign s_tready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	u8u16_dec u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_byte     (byte_s1),
		.end_of_text (end_s1),
		.grp         (grp)
	);

	u8u16_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.grp      (grp),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	`U8U16_ASSERT(a_flush_empties, advance && end_s1 |=> u_dec.pend_cnt_q == 2'd0, "pending bytes left after end of text")
	`U8U16_ASSERT(a_end_gives_unit, advance && end_s1 |=> m_tvalid, "end of text produced no unit")
	`U8U16_ASSERT(a_group_fits, advance |-> grp.count <= 3'(MaxUnits), "one byte decoded into too many units")
	`U8U16_ASSERT_ALWAYS(a_done_on_last, m_tvalid && m_tuser |-> m_tlast, "text done without last of run")

endmodule
